// ===== design/tcx_pkg.sv =====
// ----------------------------------------------------------------------------
// tcx_pkg
// Shared types, constants and microcode store of the execute unit.
// ----------------------------------------------------------------------------
package tcx_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int PC_WIDTH    = 16;
  localparam int REG_COUNT   = 16;
  localparam int REG_IDX_W   = 4;
  localparam int KIND_W      = 4;
  localparam int OPND_W      = 8;
  localparam int BYTE_ADDR_W = 8;
  localparam int UADDR_W     = 5;

  // Instruction kinds
  localparam logic [KIND_W-1:0] KIND_LD_DIR = 4'd0;
  localparam logic [KIND_W-1:0] KIND_ST_DIR = 4'd1;
  localparam logic [KIND_W-1:0] KIND_ST_IND = 4'd2;
  localparam logic [KIND_W-1:0] KIND_LD_IMM = 4'd3;
  localparam logic [KIND_W-1:0] KIND_ADD    = 4'd4;
  localparam logic [KIND_W-1:0] KIND_SUB    = 4'd5;
  localparam logic [KIND_W-1:0] KIND_JZ     = 4'd6;
  localparam logic [KIND_W-1:0] KIND_MUL    = 4'd7;
  localparam logic [KIND_W-1:0] KIND_MOV    = 4'd8;
  localparam logic [KIND_W-1:0] KIND_LD_IND = 4'd9;

  typedef logic [UADDR_W-1:0] uaddr_t;

  typedef enum logic {
    MADDR_OPND,
    MADDR_REGB
  } maddr_sel_t;

  typedef enum logic [2:0] {
    WB_MEM,
    WB_IMM,
    WB_ADD,
    WB_SUB,
    WB_PROD,
    WB_MOVB
  } wb_sel_t;

  typedef enum logic [1:0] {
    PC_HOLD,
    PC_INC,
    PC_BRANCH
  } pc_sel_t;

  // One microcode control word
  typedef struct packed {
    logic       rf_rd;
    logic       b_lo;
    logic       mem_rd;
    logic       mem_wr;
    maddr_sel_t maddr_sel;
    logic       mul_en;
    logic       rf_wr;
    wb_sel_t    wb_sel;
    pc_sel_t    pc_sel;
    logic       br_zero;
    logic       fin;
    uaddr_t     target;
  } ctl_word_t;

  localparam ctl_word_t CW_NOP = '{
    rf_rd: 1'b0, b_lo: 1'b0, mem_rd: 1'b0, mem_wr: 1'b0, maddr_sel: MADDR_OPND,
    mul_en: 1'b0, rf_wr: 1'b0, wb_sel: WB_MEM, pc_sel: PC_HOLD, br_zero: 1'b0,
    fin: 1'b0, target: '0
  };

  // Microcode addresses
  localparam uaddr_t UA_LDD0 = 5'd0;
  localparam uaddr_t UA_LDD1 = 5'd1;
  localparam uaddr_t UA_STD0 = 5'd2;
  localparam uaddr_t UA_STD1 = 5'd3;
  localparam uaddr_t UA_STI0 = 5'd4;
  localparam uaddr_t UA_STI1 = 5'd5;
  localparam uaddr_t UA_LDI0 = 5'd6;
  localparam uaddr_t UA_ADD0 = 5'd7;
  localparam uaddr_t UA_ADD1 = 5'd8;
  localparam uaddr_t UA_SUB0 = 5'd9;
  localparam uaddr_t UA_SUB1 = 5'd10;
  localparam uaddr_t UA_MUL0 = 5'd11;
  localparam uaddr_t UA_MUL1 = 5'd12;
  localparam uaddr_t UA_MUL2 = 5'd13;
  localparam uaddr_t UA_MOV0 = 5'd14;
  localparam uaddr_t UA_MOV1 = 5'd15;
  localparam uaddr_t UA_LDX0 = 5'd16;
  localparam uaddr_t UA_LDX1 = 5'd17;
  localparam uaddr_t UA_LDX2 = 5'd18;
  localparam uaddr_t UA_JZ0  = 5'd19;
  localparam uaddr_t UA_JZ1  = 5'd20;
  localparam uaddr_t UA_JZ2  = 5'd21;
  localparam uaddr_t UA_JZ3  = 5'd22;
  localparam uaddr_t UA_NOP0 = 5'd23;

  function automatic uaddr_t ucode_entry(input logic [KIND_W-1:0] kind);
    uaddr_t ua;
    unique case (kind)
      KIND_LD_DIR: ua = UA_LDD0;
      KIND_ST_DIR: ua = UA_STD0;
      KIND_ST_IND: ua = UA_STI0;
      KIND_LD_IMM: ua = UA_LDI0;
      KIND_ADD:    ua = UA_ADD0;
      KIND_SUB:    ua = UA_SUB0;
      KIND_JZ:     ua = UA_JZ0;
      KIND_MUL:    ua = UA_MUL0;
      KIND_MOV:    ua = UA_MOV0;
      KIND_LD_IND: ua = UA_LDX0;
      default:     ua = UA_NOP0;
    endcase
    return ua;
  endfunction

  function automatic ctl_word_t ucode_rom(input uaddr_t ua);
    ctl_word_t cw;
    cw = CW_NOP;
    unique case (ua)
      UA_LDD0: begin
        cw.mem_rd = 1'b1;
      end
      UA_LDD1: begin
        cw.rf_wr = 1'b1; cw.wb_sel = WB_MEM; cw.pc_sel = PC_INC; cw.fin = 1'b1;
      end
      UA_STD0: cw.rf_rd = 1'b1;
      UA_STD1: begin
        cw.mem_wr = 1'b1; cw.pc_sel = PC_INC; cw.fin = 1'b1;
      end
      UA_STI0: begin
        cw.rf_rd = 1'b1; cw.b_lo = 1'b1;
      end
      UA_STI1: begin
        cw.mem_wr = 1'b1; cw.maddr_sel = MADDR_REGB; cw.pc_sel = PC_INC; cw.fin = 1'b1;
      end
      UA_LDI0: begin
        cw.rf_wr = 1'b1; cw.wb_sel = WB_IMM; cw.pc_sel = PC_INC; cw.fin = 1'b1;
      end
      UA_ADD0: cw.rf_rd = 1'b1;
      UA_ADD1: begin
        cw.rf_wr = 1'b1; cw.wb_sel = WB_ADD; cw.pc_sel = PC_INC; cw.fin = 1'b1;
      end
      UA_SUB0: cw.rf_rd = 1'b1;
      UA_SUB1: begin
        cw.rf_wr = 1'b1; cw.wb_sel = WB_SUB; cw.pc_sel = PC_INC; cw.fin = 1'b1;
      end
      UA_MUL0: cw.rf_rd = 1'b1;
      UA_MUL1: cw.mul_en = 1'b1;
      UA_MUL2: begin
        cw.rf_wr = 1'b1; cw.wb_sel = WB_PROD; cw.pc_sel = PC_INC; cw.fin = 1'b1;
      end
      UA_MOV0: cw.rf_rd = 1'b1;
      UA_MOV1: begin
        cw.rf_wr = 1'b1; cw.wb_sel = WB_MOVB; cw.pc_sel = PC_INC; cw.fin = 1'b1;
      end
      UA_LDX0: begin
        cw.rf_rd = 1'b1; cw.b_lo = 1'b1;
      end
      UA_LDX1: begin
        cw.mem_rd = 1'b1; cw.maddr_sel = MADDR_REGB;
      end
      UA_LDX2: begin
        cw.rf_wr = 1'b1; cw.wb_sel = WB_MEM; cw.pc_sel = PC_INC; cw.fin = 1'b1;
      end
      UA_JZ0: cw.rf_rd = 1'b1;
      UA_JZ1: begin
        cw.br_zero = 1'b1; cw.target = UA_JZ3;
      end
      UA_JZ2: begin
        cw.pc_sel = PC_INC; cw.fin = 1'b1;
      end
      UA_JZ3: begin
        cw.pc_sel = PC_BRANCH; cw.fin = 1'b1;
      end
      default: begin
        // Unused kinds and unused words: finish with no write, PC held
        cw.fin = 1'b1;
      end
    endcase
    return cw;
  endfunction

endpackage

// ===== design/tcx_ucode_seq.sv =====
// ----------------------------------------------------------------------------
// tcx_ucode_seq
// Microcode step counter: dispatches on the kind, steps, branches on zero.
// ----------------------------------------------------------------------------
module tcx_ucode_seq
  import tcx_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start_xfer,
  input  logic [KIND_W-1:0] kind,
  input  logic              a_zero,
  output ctl_word_t         cw,
  output logic              busy
);

  uaddr_t uaddr_r, uaddr_nxt;
  logic   active_r, active_nxt;

  assign cw   = active_r ? ucode_rom(uaddr_r) : CW_NOP;
  assign busy = active_r && !cw.fin;

  always_comb begin
    uaddr_nxt  = uaddr_r;
    active_nxt = active_r;
    if (start_xfer) begin
      uaddr_nxt  = ucode_entry(kind);
      active_nxt = 1'b1;
    end else if (active_r) begin
      if (cw.fin) begin
        active_nxt = 1'b0;
      end else if (cw.br_zero && a_zero) begin
        uaddr_nxt = cw.target;
      end else begin
        uaddr_nxt = uaddr_r + UADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uaddr_r  <= '0;
      active_r <= 1'b0;
    end else begin
      uaddr_r  <= uaddr_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

// ===== design/tcx_regfile.sv =====
// ----------------------------------------------------------------------------
// tcx_regfile
// Register file, two registered read ports, one write port, zero after reset.
// ----------------------------------------------------------------------------
module tcx_regfile
  import tcx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [REG_IDX_W-1:0]  rd_a_idx,
  input  logic [REG_IDX_W-1:0]  rd_b_idx,
  output logic [DATA_WIDTH-1:0] rd_a_data,
  output logic [DATA_WIDTH-1:0] rd_b_data,
  input  logic                  wr_en,
  input  logic [REG_IDX_W-1:0]  wr_idx,
  input  logic [DATA_WIDTH-1:0] wr_data
);

  logic [DATA_WIDTH-1:0] mem [REG_COUNT];
  logic [REG_COUNT-1:0]  vld_r;
  logic [DATA_WIDTH-1:0] a_q_r, b_q_r;
  logic                  a_v_r, b_v_r;

  // Entries never written read as zero
  assign rd_a_data = a_v_r ? a_q_r : '0;
  assign rd_b_data = b_v_r ? b_q_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        a_v_r <= vld_r[rd_a_idx];
        b_v_r <= vld_r[rd_b_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      a_q_r <= mem[rd_a_idx];
      b_q_r <= mem[rd_b_idx];
    end
  end

endmodule

// ===== design/tcx_data_mem.sv =====
// ----------------------------------------------------------------------------
// tcx_data_mem
// Single-port data memory with registered read, zero after reset.
// ----------------------------------------------------------------------------
module tcx_data_mem
  import tcx_pkg::*;
#(
  parameter int MEM_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic                         wr_en,
  input  logic [$clog2(MEM_DEPTH)-1:0] addr,
  input  logic [DATA_WIDTH-1:0]        wr_data,
  output logic [DATA_WIDTH-1:0]        rd_data
);

  logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]  vld_r;
  logic [DATA_WIDTH-1:0] q_r;
  logic                  q_v_r;

  assign rd_data = q_v_r ? q_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      q_v_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[addr] <= 1'b1;
      end
      if (rd_en) begin
        q_v_r <= vld_r[addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[addr];
    end
  end

endmodule

// ===== design/tiny_cpu_execute_unit.sv =====
// ----------------------------------------------------------------------------
// tiny_cpu_execute_unit
// Executes decoded instructions against a register file, data memory and PC.
// ----------------------------------------------------------------------------
// Usage:
//   Drive start with in_kind, in_dest_reg and in_operand; the instruction
//   transfers at a rising edge where start is high and busy is low. One
//   instruction is in flight at a time.
//   Every instruction gives exactly one result: out_valid is high for one
//   cycle with the new PC and any register or memory write on the out_
//   ports; fields of a write that did not happen read zero.
//   Each instruction runs a microcode program, one control word per cycle;
//   busy drops on its final word, so the next instruction can transfer at
//   the edge that captures the result. Load immediate and unused kinds
//   finish in their first word. Load direct reads memory, then writes;
//   stores, add, sub and move read the register file, then write.
//   Multiply reads, then registers the product, then writes. Load indirect
//   reads Rb, then the data memory, the two registered reads in series,
//   then writes. Jump if zero reads Ra, tests it for zero, then finishes
//   with the PC incremented or branched.
//   Reset clears the PC; register file and data memory read zero until
//   written, with no clearing pass. The receiver cannot stall: results are
//   presented once and not held.
// ----------------------------------------------------------------------------
module tiny_cpu_execute_unit
  import tcx_pkg::*;
#(
  parameter int MEM_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [KIND_W-1:0]            in_kind,
  input  logic [REG_IDX_W-1:0]         in_dest_reg,
  input  logic [OPND_W-1:0]            in_operand,
  output logic                         out_valid,
  output logic [PC_WIDTH-1:0]          out_next_pc,
  output logic                         out_reg_written,
  output logic [REG_IDX_W-1:0]         out_reg_index,
  output logic signed [DATA_WIDTH-1:0] out_reg_value,
  output logic                         out_mem_written,
  output logic [BYTE_ADDR_W-1:0]       out_mem_address,
  output logic signed [DATA_WIDTH-1:0] out_mem_value
);

  localparam int MEM_AW  = $clog2(MEM_DEPTH);
  localparam int FOLD_N  = 1 << BYTE_ADDR_W;
  localparam int FOLD_W  = FOLD_N * MEM_AW;

  // Byte address folded onto the memory depth, built at elaboration
  function automatic logic [FOLD_W-1:0] build_fold();
    logic [FOLD_W-1:0] tbl;
    int                cnt;
    tbl = '0;
    cnt = 0;
    for (int i = 0; i < FOLD_N; i++) begin
      tbl[i*MEM_AW +: MEM_AW] = MEM_AW'(cnt);
      cnt = (cnt == MEM_DEPTH - 1) ? 0 : cnt + 1;
    end
    return tbl;
  endfunction

  localparam logic [FOLD_W-1:0] FOLD_TBL = build_fold();

  ctl_word_t cw;
  logic      start_xfer;

  // Instruction latched at transfer
  logic [REG_IDX_W-1:0]  rn_r;
  logic [OPND_W-1:0]     opnd_r;

  logic [PC_WIDTH-1:0]   pc_r, pc_nxt, pc_inc;
  logic [DATA_WIDTH-1:0] prod_r;
  logic [DATA_WIDTH-1:0] rf_a, rf_b, mem_q;
  logic [DATA_WIDTH-1:0] wb_val;
  logic [BYTE_ADDR_W-1:0] maddr_byte;
  logic [MEM_AW-1:0]     maddr;
  logic [REG_IDX_W-1:0]  rd_b_idx;
  logic                  a_zero;

  // Result registers
  logic                  out_valid_r;
  logic [PC_WIDTH-1:0]   out_next_pc_r;
  logic                  out_reg_written_r;
  logic [REG_IDX_W-1:0]  out_reg_index_r;
  logic [DATA_WIDTH-1:0] out_reg_value_r;
  logic                  out_mem_written_r;
  logic [BYTE_ADDR_W-1:0] out_mem_address_r;
  logic [DATA_WIDTH-1:0] out_mem_value_r;

  assign start_xfer = start && !busy;

  tcx_ucode_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_xfer (start_xfer),
    .kind       (in_kind),
    .a_zero     (a_zero),
    .cw         (cw),
    .busy       (busy)
  );

  // Second read port picks the high nibble (arithmetic, move) or the low
  // nibble (indirect address) of the operand
  assign rd_b_idx = cw.b_lo ? opnd_r[REG_IDX_W-1:0] : opnd_r[OPND_W-1 -: REG_IDX_W];

  tcx_regfile u_rf (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (cw.rf_rd),
    .rd_a_idx  (rn_r),
    .rd_b_idx  (rd_b_idx),
    .rd_a_data (rf_a),
    .rd_b_data (rf_b),
    .wr_en     (cw.rf_wr),
    .wr_idx    (rn_r),
    .wr_data   (wb_val)
  );

  // Direct address from the operand, indirect from the low byte of Rb
  assign maddr_byte = (cw.maddr_sel == MADDR_REGB) ? rf_b[BYTE_ADDR_W-1:0] : opnd_r;
  assign maddr      = FOLD_TBL[maddr_byte*MEM_AW +: MEM_AW];

  tcx_data_mem #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_dmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (cw.mem_rd),
    .wr_en   (cw.mem_wr),
    .addr    (maddr),
    .wr_data (rf_a),
    .rd_data (mem_q)
  );

  assign a_zero = (rf_a == '0);

  // Write-back select; arithmetic wraps at the data width
  always_comb begin
    case (cw.wb_sel)
      WB_MEM:  wb_val = mem_q;
      WB_IMM:  wb_val = DATA_WIDTH'(opnd_r);
      WB_ADD:  wb_val = rf_a + rf_b;
      WB_SUB:  wb_val = rf_a - rf_b;
      WB_PROD: wb_val = prod_r;
      WB_MOVB: wb_val = rf_b;
      default: wb_val = '0;
    endcase
  end

  // Taken jump adds the sign-extended offset to the incremented PC
  assign pc_inc = pc_r + PC_WIDTH'(1);

  always_comb begin
    case (cw.pc_sel)
      PC_INC:    pc_nxt = pc_inc;
      PC_BRANCH: pc_nxt = pc_inc + {{(PC_WIDTH-OPND_W){opnd_r[OPND_W-1]}}, opnd_r};
      default:   pc_nxt = pc_r;
    endcase
  end

  // Hold the instruction fields for the length of its program
  always_ff @(posedge clk) begin
    if (start_xfer) begin
      rn_r   <= in_dest_reg;
      opnd_r <= in_operand;
    end
    if (cw.mul_en) begin
      prod_r <= rf_a * rf_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cw.fin;
      if (cw.fin) begin
        pc_r <= pc_nxt;
      end
    end
  end

  // Capture the result on the final step; drop unused fields to zero
  always_ff @(posedge clk) begin
    if (cw.fin) begin
      out_next_pc_r     <= pc_nxt;
      out_reg_written_r <= cw.rf_wr;
      out_reg_index_r   <= cw.rf_wr ? rn_r : '0;
      out_reg_value_r   <= cw.rf_wr ? wb_val : '0;
      out_mem_written_r <= cw.mem_wr;
      out_mem_address_r <= cw.mem_wr ? BYTE_ADDR_W'(maddr) : '0;
      out_mem_value_r   <= cw.mem_wr ? rf_a : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_next_pc     = out_next_pc_r;
  assign out_reg_written = out_reg_written_r;
  assign out_reg_index   = out_reg_index_r;
  assign out_reg_value   = out_reg_value_r;
  assign out_mem_written = out_mem_written_r;
  assign out_mem_address = out_mem_address_r;
  assign out_mem_value   = out_mem_value_r;

endmodule
